// ----- rtl/core/distinct_value_counter_macros.svh -----
// Assertion macros for the distinct value counter.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DISTINCT_VALUE_COUNTER_MACROS_SVH
`define DISTINCT_VALUE_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define DVC_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("distinct_value_counter: assertion failed");
// next-cycle implication, disabled during reset
`define DVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("distinct_value_counter: assertion failed");
`else
`define DVC_ASSERT(label, clk, rst_n, ante, cons)
`define DVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/dvc_pkg.sv -----
// Shared types for the distinct value counter: item structs, table entry,
// controller states and the command/status groups. No dependencies.
package dvc_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 32;

    // one input item
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_of_array;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [5:0]         slot;
        logic [COUNT_W-1:0] occurrences;
        logic               is_new;
        logic               dropped;
        logic [6:0]         distinct_total;
        logic               batch_end;
    } t_out_item;

    // one table entry as stored in the RAM
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish_hit;
        logic finish_miss;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic exhausted;
    } t_dp_status;

endpackage

// ----- rtl/core/dvc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dvc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dvc_datapath.sv -----
// Datapath of the distinct value counter: item register, scan pointer,
// compare stage, occupancy counter, result register and the table RAM.
// Depends on dvc_pkg, dvc_ram and distinct_value_counter_macros.svh.
`include "distinct_value_counter_macros.svh"

module dvc_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dvc_pkg::t_ctl_cmd  i_cmd,
    input  dvc_pkg::t_in_item  i_in_item,
    output dvc_pkg::t_dp_status o_status,
    output dvc_pkg::t_out_item o_out_item
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int OW = $clog2(TABLE_DEPTH + 1);

    dvc_pkg::t_in_item  r_item;
    dvc_pkg::t_out_item r_out;
    dvc_pkg::t_out_item n_out;
    logic [OW-1:0]      r_occ;
    logic [OW-1:0]      r_idx;
    logic [AW-1:0]      r_cmp_idx;
    logic               r_cmp_vld;

    dvc_pkg::t_entry    rd_entry;
    logic [dvc_pkg::ENTRY_W-1:0] ram_rdata;
    logic [dvc_pkg::ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_waddr;
    logic               ram_we;
    logic               issue;
    logic               hit;
    logic               full;
    logic [dvc_pkg::COUNT_W-1:0] inc_count;

    // scan: one read issued per cycle, compared in the following cycle
    assign issue     = i_cmd.scan && (r_idx < r_occ);
    assign full      = (r_occ == OW'(TABLE_DEPTH));
    assign rd_entry  = dvc_pkg::t_entry'(ram_rdata);
    assign hit       = r_cmp_vld && (rd_entry.value == r_item.value);
    assign inc_count = (rd_entry.count == dvc_pkg::COUNT_MAX) ? rd_entry.count
                                                              : rd_entry.count + 1'b1;

    assign o_status.hit       = hit;
    assign o_status.exhausted = !issue && !r_cmp_vld;

    // table write: count update on a hit, append on a miss with room
    always_comb begin
        ram_we    = i_cmd.finish_hit || (i_cmd.finish_miss && !full);
        ram_waddr = i_cmd.finish_hit ? r_cmp_idx : r_occ[AW-1:0];
        ram_wdata = i_cmd.finish_hit ? {r_item.value, inc_count}
                                     : {r_item.value, dvc_pkg::COUNT_ONE};
    end

    // result assembly
    always_comb begin
        n_out           = r_out;
        n_out.batch_end = r_item.last_of_array;
        if (i_cmd.finish_hit) begin
            n_out.slot           = 6'(r_cmp_idx);
            n_out.occurrences    = inc_count;
            n_out.is_new         = 1'b0;
            n_out.dropped        = 1'b0;
            n_out.distinct_total = 7'(r_occ);
        end else if (!full) begin
            n_out.slot           = 6'(r_occ);
            n_out.occurrences    = dvc_pkg::COUNT_ONE;
            n_out.is_new         = 1'b1;
            n_out.dropped        = 1'b0;
            n_out.distinct_total = 7'(r_occ + 1'b1);
        end else begin
            n_out.slot           = '0;
            n_out.occurrences    = '0;
            n_out.is_new         = 1'b0;
            n_out.dropped        = 1'b1;
            n_out.distinct_total = 7'(r_occ);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.finish_miss && !full) begin
                r_occ <= r_occ + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_idx[AW-1:0];
        end
        if (i_cmd.finish_hit || i_cmd.finish_miss) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

    dvc_ram #(
        .WIDTH (dvc_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // checks
    `DVC_ASSERT(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OW'(TABLE_DEPTH))
    `DVC_ASSERT(a_cmp_in_table, i_clk, i_rst_n, r_cmp_vld, OW'(r_cmp_idx) < r_occ)
    `DVC_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, i_cmd.finish_miss && !full, r_occ == OW'($past(r_occ) + 1'b1))
    `DVC_ASSERT_NEXT(a_hit_keeps_occ, i_clk, i_rst_n, i_cmd.finish_hit, r_occ == $past(r_occ))

endmodule

// ----- rtl/core/dvc_ctrl.sv -----
// Controller of the distinct value counter: sequences accept, table scan
// and result hand-off. Depends on dvc_pkg.
module dvc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  dvc_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output dvc_pkg::t_ctl_cmd   o_cmd
);

    dvc_pkg::t_state r_state;
    dvc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            dvc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dvc_pkg::ST_SCAN;
                end
            end
            dvc_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit) begin
                    o_cmd.finish_hit = 1'b1;
                    n_state          = dvc_pkg::ST_RESULT;
                end else if (i_status.exhausted) begin
                    o_cmd.finish_miss = 1'b1;
                    n_state           = dvc_pkg::ST_RESULT;
                end
            end
            dvc_pkg::ST_RESULT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = dvc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dvc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/distinct_value_counter.sv -----
// Distinct value counter: table of first-seen values with saturating counts.
// Entries are read in slot order through the registered RAM read port, one per
// cycle, and each is compared with the item: a hit ends the scan, and a miss is
// found once every occupied entry has been compared. No new item is accepted
// until the previous result has been taken. Reset (synchronous, active low)
// clears occupancy and control state.
module distinct_value_counter #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dvc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dvc_pkg::t_out_item o_out_item
);

    dvc_pkg::t_ctl_cmd   cmd;
    dvc_pkg::t_dp_status status;

    dvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    dvc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule
